// ----- rtl/ecc_pkg.sv -----
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int MAX_DEPTH      = 4;
    localparam int MAX_REFINEMENT = 4;
    localparam int RADIUS_BITS    = 6;

    localparam int SP_W    = $clog2(MAX_DEPTH);
    localparam int LEV_W   = $clog2(MAX_DEPTH + 1);
    localparam int COORD_W = 18;
    localparam int MAG_W   = 17;
    localparam int R2_W    = 2 * RADIUS_BITS;
    localparam int COEF_W  = 4 * RADIUS_BITS;
    localparam int PW_W    = 9;
    localparam int SIZE_W  = PW_W + 1;
    localparam int CH_W    = 7;
    localparam int WEIGHT_W = 26;
    localparam int BND_W   = 54;
    localparam int SUM_W   = 56;
    localparam int MUL_W   = 32;
    localparam int STEP_W  = 5;

    // register indexes
    localparam logic [2:0] REG_DIMENSIONS = 3'd0;
    localparam logic [2:0] REG_RADIUS_X   = 3'd1;
    localparam logic [2:0] REG_RADIUS_Y   = 3'd2;
    localparam logic [2:0] REG_RADIUS_Z   = 3'd3;
    localparam logic [2:0] REG_DEPTH      = 3'd4;
    localparam logic [2:0] REG_REFINEMENT = 3'd5;

    // setup program steps
    localparam logic [STEP_W-1:0] ST_RX2   = 5'd0;
    localparam logic [STEP_W-1:0] ST_RY2   = 5'd1;
    localparam logic [STEP_W-1:0] ST_RZ2   = 5'd2;
    localparam logic [STEP_W-1:0] ST_CZ    = 5'd3;
    localparam logic [STEP_W-1:0] ST_CX    = 5'd4;
    localparam logic [STEP_W-1:0] ST_CY    = 5'd5;
    localparam logic [STEP_W-1:0] ST_CH0   = 5'd6;
    localparam logic [STEP_W-1:0] ST_CH1   = 5'd7;
    localparam logic [STEP_W-1:0] ST_PW    = 5'd8;
    localparam logic [STEP_W-1:0] ST_FL    = ST_PW + STEP_W'(MAX_DEPTH);
    localparam logic [STEP_W-1:0] ST_S2    = ST_FL + STEP_W'(MAX_DEPTH);
    localparam logic [STEP_W-1:0] ST_B1    = ST_S2 + 5'd1;
    localparam logic [STEP_W-1:0] ST_B2    = ST_S2 + 5'd2;
    localparam logic [STEP_W-1:0] ST_OX    = ST_S2 + 5'd3;
    localparam logic [STEP_W-1:0] ST_OY    = ST_S2 + 5'd4;
    localparam logic [STEP_W-1:0] ST_OZ    = ST_S2 + 5'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SQ,
        S_CF,
        S_CMP,
        S_ADV,
        S_DONE
    } state_t;

endpackage

// ----- rtl/ellipse_cell_coverage.sv -----
`timescale 1ns / 1ps

// Coverage of one pixel/voxel by an axis-aligned ellipse or ellipsoid.
// Input channel: in_valid/in_stall with offset_x/y/z; a word is taken when
// in_valid is high and in_stall low. Output channel: out_valid/out_stall with
// weight_units, one result word per input word, in order.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle;
// the user is bound to this, the block itself does not enforce it. Work: the
// setup program, then for each visited subcell a square and a coefficient step
// per axis and a compare per corner tested, a step per sibling or pop, and a
// post of the result. All products come from one shared 32x32 multiplier, so
// one word is in work at a time; in_stall is high until it is done.
// The finished result sits in an output register, so a new word may be
// taken while out_stall holds the previous one; a stalled result does not
// change. Reset clears the sequencer, drops out_valid and loads the
// register defaults: 2D, radii 1, depth 3, refinement 2.
module ellipse_cell_coverage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [5:0]                        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [6:0]                 offset_x,
    input  logic signed [6:0]                 offset_y,
    input  logic signed [6:0]                 offset_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ecc_pkg::WEIGHT_W-1:0]      weight_units
);

    // configuration
    logic [1:0] dims_reg;
    logic [5:0] rx_reg, ry_reg, rz_reg;
    logic [2:0] depth_reg, refine_reg;

    ecc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic [ecc_pkg::STEP_W-1:0] step_reg, step_next;

    // datapath
    logic [6:0] ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;
    logic [ecc_pkg::R2_W-1:0] rx2_reg, ry2_reg, rz2_reg, rx2_next, ry2_next, rz2_next;
    logic [ecc_pkg::COEF_W-1:0] coef_reg [3];
    logic [ecc_pkg::COEF_W-1:0] coef_next [3];
    logic [ecc_pkg::CH_W-1:0] ch_reg, ch_next;
    logic [ecc_pkg::PW_W-1:0] pw_reg [ecc_pkg::MAX_DEPTH+1];
    logic [ecc_pkg::PW_W-1:0] pw_next [ecc_pkg::MAX_DEPTH+1];
    logic [ecc_pkg::WEIGHT_W-1:0] fl_reg [ecc_pkg::MAX_DEPTH+1];
    logic [ecc_pkg::WEIGHT_W-1:0] fl_next [ecc_pkg::MAX_DEPTH+1];
    logic [ecc_pkg::BND_W-1:0] bnd_reg, bnd_next;
    logic signed [ecc_pkg::COORD_W-1:0] org_reg [3];
    logic signed [ecc_pkg::COORD_W-1:0] org_next [3];
    logic signed [ecc_pkg::COORD_W-1:0] ostk_reg [3][ecc_pkg::MAX_DEPTH];
    logic signed [ecc_pkg::COORD_W-1:0] ostk_next [3][ecc_pkg::MAX_DEPTH];
    logic [5:0] idx_stk_reg [ecc_pkg::MAX_DEPTH];
    logic [5:0] idx_stk_next [ecc_pkg::MAX_DEPTH];
    logic [ecc_pkg::LEV_W-1:0] lev_reg, lev_next;
    logic [2:0] corner_reg, corner_next;
    logic [1:0] axis_reg, axis_next;
    logic seen_in_reg, seen_in_next, seen_out_reg, seen_out_next;
    logic [ecc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [2*ecc_pkg::MUL_W-1:0] prod_reg, prod_next;
    logic [ecc_pkg::WEIGHT_W-1:0] acc_reg, acc_next;
    logic [ecc_pkg::WEIGHT_W-1:0] weight_reg, weight_next;

    logic [ecc_pkg::MUL_W-1:0] mul_a, mul_b;
    logic [2*ecc_pkg::MUL_W-1:0] mul_p;

    ecc_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // effective settings
    logic three_d;
    logic [2:0] d_eff, r_eff;
    logic [5:0] rx_e, ry_e, rz_e;
    assign three_d = (dims_reg == 2'd3);
    assign d_eff = (depth_reg > 3'(ecc_pkg::MAX_DEPTH)) ? 3'(ecc_pkg::MAX_DEPTH) : depth_reg;
    assign r_eff = (refine_reg == 3'd0) ? 3'd1 :
                   (refine_reg > 3'(ecc_pkg::MAX_REFINEMENT)) ?
                   3'(ecc_pkg::MAX_REFINEMENT) : refine_reg;
    assign rx_e = (rx_reg == 6'd0) ? 6'd1 : rx_reg;
    assign ry_e = (ry_reg == 6'd0) ? 6'd1 : ry_reg;
    assign rz_e = (rz_reg == 6'd0) ? 6'd1 : rz_reg;

    assign in_stall     = (state_reg != ecc_pkg::S_IDLE);
    assign out_valid    = out_valid_reg;
    assign weight_units = weight_reg;

    always_comb
    begin
        logic [2:0] left;
        logic [ecc_pkg::SIZE_W-1:0] size;
        logic signed [ecc_pkg::COORD_W-1:0] coord;
        logic [ecc_pkg::COORD_W-1:0] cmag;
        logic [ecc_pkg::SUM_W:0] total;
        logic in_now, any_in, any_out, last_corner, last_axis;
        logic [ecc_pkg::SP_W-1:0] sp, push_sp;
        logic [ecc_pkg::LEV_W-1:0] lev_m1;
        logic [1:0] ci, cj, ck, rm1;
        logic [2:0] tidx;
        logic [6:0] omag;
        logic oneg;
        logic signed [ecc_pkg::COORD_W-1:0] tv, start;

        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        step_next      = step_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        oz_next = oz_reg;
        rx2_next = rx2_reg;
        ry2_next = ry2_reg;
        rz2_next = rz2_reg;
        coef_next = coef_reg;
        ch_next = ch_reg;
        pw_next = pw_reg;
        fl_next = fl_reg;
        bnd_next = bnd_reg;
        org_next = org_reg;
        ostk_next = ostk_reg;
        idx_stk_next = idx_stk_reg;
        lev_next = lev_reg;
        corner_next = corner_reg;
        axis_next = axis_reg;
        seen_in_next = seen_in_reg;
        seen_out_next = seen_out_reg;
        sum_next = sum_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        weight_next = weight_reg;
        mul_a = '0;
        mul_b = '0;

        left   = d_eff - 3'(lev_reg);
        size   = {pw_reg[left], 1'b0};
        coord  = org_reg[axis_reg] +
                 (corner_reg[axis_reg] ? $signed({8'd0, size}) : 18'sd0);
        cmag   = (coord < 0) ? 18'(-coord) : 18'(coord);
        total  = {1'b0, sum_reg} + {1'b0, prod_reg[ecc_pkg::SUM_W-1:0]};
        in_now = (total <= {3'd0, bnd_reg});
        any_in  = seen_in_reg || in_now;
        any_out = seen_out_reg || !in_now;
        last_corner = (corner_reg == (three_d ? 3'd7 : 3'd3));
        last_axis   = (axis_reg == (three_d ? 2'd2 : 2'd1));
        lev_m1  = lev_reg - 1'b1;
        sp      = lev_m1[ecc_pkg::SP_W-1:0];
        push_sp = lev_reg[ecc_pkg::SP_W-1:0];
        ci  = idx_stk_reg[sp][5:4];
        cj  = idx_stk_reg[sp][3:2];
        ck  = idx_stk_reg[sp][1:0];
        rm1 = 2'(r_eff - 3'd1);
        tidx = 3'd0;
        omag = 7'd0;
        oneg = 1'b0;
        tv = '0;
        start = '0;

        case (state_reg)
            ecc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ox_next = offset_x;
                    oy_next = offset_y;
                    oz_next = offset_z;
                    step_next = ecc_pkg::ST_RX2;
                    state_next = ecc_pkg::S_SETUP;
                end
            end

            ecc_pkg::S_SETUP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == ecc_pkg::ST_RX2)
                begin
                    mul_a = 32'(rx_e);
                    mul_b = 32'(rx_e);
                    rx2_next = mul_p[ecc_pkg::R2_W-1:0];
                    pw_next[0] = 9'd1;
                    fl_next[0] = 26'd2;
                end
                else if (step_reg == ecc_pkg::ST_RY2)
                begin
                    mul_a = 32'(ry_e);
                    mul_b = 32'(ry_e);
                    ry2_next = mul_p[ecc_pkg::R2_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_RZ2)
                begin
                    mul_a = three_d ? 32'(rz_e) : 32'd1;
                    mul_b = mul_a;
                    rz2_next = mul_p[ecc_pkg::R2_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_CZ)
                begin
                    mul_a = 32'(rx2_reg);
                    mul_b = 32'(ry2_reg);
                    coef_next[2] = mul_p[ecc_pkg::COEF_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_CX)
                begin
                    mul_a = 32'(ry2_reg);
                    mul_b = 32'(rz2_reg);
                    coef_next[0] = mul_p[ecc_pkg::COEF_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_CY)
                begin
                    mul_a = 32'(rx2_reg);
                    mul_b = 32'(rz2_reg);
                    coef_next[1] = mul_p[ecc_pkg::COEF_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_CH0)
                begin
                    mul_a = 32'(r_eff);
                    mul_b = 32'(r_eff);
                    ch_next = mul_p[ecc_pkg::CH_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_CH1)
                begin
                    mul_a = 32'(ch_reg);
                    mul_b = three_d ? 32'(r_eff) : 32'd1;
                    ch_next = mul_p[ecc_pkg::CH_W-1:0];
                end
                else if (step_reg < ecc_pkg::ST_FL)
                begin
                    // pw[n] = refinement^n
                    tidx = 3'(step_reg - ecc_pkg::ST_PW);
                    mul_a = 32'(pw_reg[tidx]);
                    mul_b = 32'(r_eff);
                    pw_next[tidx + 3'd1] = mul_p[ecc_pkg::PW_W-1:0];
                end
                else if (step_reg < ecc_pkg::ST_S2)
                begin
                    // fl[n] = 2 * children^n, the full weight of a cell n levels up
                    tidx = 3'(step_reg - ecc_pkg::ST_FL);
                    mul_a = 32'(fl_reg[tidx]);
                    mul_b = 32'(ch_reg);
                    fl_next[tidx + 3'd1] = mul_p[ecc_pkg::WEIGHT_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_S2)
                begin
                    mul_a = 32'({pw_reg[d_eff], 1'b0});
                    mul_b = mul_a;
                    bnd_next = mul_p[ecc_pkg::BND_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_B1)
                begin
                    mul_a = bnd_reg[31:0];
                    mul_b = 32'(rx2_reg);
                    bnd_next = mul_p[ecc_pkg::BND_W-1:0];
                end
                else if (step_reg == ecc_pkg::ST_B2)
                begin
                    mul_a = bnd_reg[31:0];
                    mul_b = 32'(coef_reg[0]);
                    bnd_next = mul_p[ecc_pkg::BND_W-1:0];
                end
                else
                begin
                    // cell origin: offset * scale - half scale
                    if (step_reg == ecc_pkg::ST_OX)
                    begin
                        oneg = ox_reg[6];
                        omag = oneg ? 7'(-ox_reg) : ox_reg;
                    end
                    else if (step_reg == ecc_pkg::ST_OY)
                    begin
                        oneg = oy_reg[6];
                        omag = oneg ? 7'(-oy_reg) : oy_reg;
                    end
                    else
                    begin
                        oneg = three_d && oz_reg[6];
                        omag = !three_d ? 7'd0 : (oz_reg[6] ? 7'(-oz_reg) : oz_reg);
                    end
                    mul_a = 32'(omag);
                    mul_b = 32'({pw_reg[d_eff], 1'b0});
                    tv = $signed({1'b0, mul_p[16:0]});
                    start = (oneg ? -tv : tv) - $signed({9'd0, pw_reg[d_eff]});
                    if (!three_d && step_reg == ecc_pkg::ST_OZ)
                        start = '0;
                    if (step_reg == ecc_pkg::ST_OX)
                        org_next[0] = start;
                    else if (step_reg == ecc_pkg::ST_OY)
                        org_next[1] = start;
                    else
                    begin
                        org_next[2] = start;
                        lev_next = '0;
                        acc_next = '0;
                        corner_next = 3'd0;
                        axis_next = 2'd0;
                        seen_in_next = 1'b0;
                        seen_out_next = 1'b0;
                        state_next = ecc_pkg::S_SQ;
                    end
                end
            end

            ecc_pkg::S_SQ:
            begin
                sum_next = (axis_reg == 2'd0) ? '0 :
                           sum_reg + prod_reg[ecc_pkg::SUM_W-1:0];
                mul_a = 32'(cmag[ecc_pkg::MAG_W-1:0]);
                mul_b = mul_a;
                prod_next = mul_p;
                state_next = ecc_pkg::S_CF;
            end

            ecc_pkg::S_CF:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 32'(coef_reg[axis_reg]);
                prod_next = mul_p;
                if (last_axis)
                    state_next = ecc_pkg::S_CMP;
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    state_next = ecc_pkg::S_SQ;
                end
            end

            ecc_pkg::S_CMP:
            begin
                axis_next = 2'd0;
                seen_in_next = any_in;
                seen_out_next = any_out;
                if (any_in && any_out)
                begin
                    // partly covered: half weight at the bottom, else split
                    corner_next = 3'd0;
                    seen_in_next = 1'b0;
                    seen_out_next = 1'b0;
                    if (left == 3'd0)
                    begin
                        acc_next = acc_reg + (fl_reg[0] >> 1);
                        state_next = ecc_pkg::S_ADV;
                    end
                    else
                    begin
                        ostk_next[0][push_sp] = org_reg[0];
                        ostk_next[1][push_sp] = org_reg[1];
                        ostk_next[2][push_sp] = org_reg[2];
                        idx_stk_next[push_sp] = 6'd0;
                        lev_next = lev_reg + 1'b1;
                        state_next = ecc_pkg::S_SQ;
                    end
                end
                else if (last_corner)
                begin
                    if (any_in)
                        acc_next = acc_reg + fl_reg[left];
                    corner_next = 3'd0;
                    seen_in_next = 1'b0;
                    seen_out_next = 1'b0;
                    state_next = ecc_pkg::S_ADV;
                end
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next = ecc_pkg::S_SQ;
                end
            end

            ecc_pkg::S_ADV:
            begin
                if (lev_reg == '0)
                    state_next = ecc_pkg::S_DONE;
                else if (three_d && ck < rm1)
                begin
                    idx_stk_next[sp] = {ci, cj, ck + 2'd1};
                    org_next[2] = org_reg[2] + $signed({8'd0, size});
                    state_next = ecc_pkg::S_SQ;
                end
                else if (cj < rm1)
                begin
                    idx_stk_next[sp] = {ci, cj + 2'd1, 2'd0};
                    org_next[1] = org_reg[1] + $signed({8'd0, size});
                    org_next[2] = ostk_reg[2][sp];
                    state_next = ecc_pkg::S_SQ;
                end
                else if (ci < rm1)
                begin
                    idx_stk_next[sp] = {ci + 2'd1, 2'd0, 2'd0};
                    org_next[0] = org_reg[0] + $signed({8'd0, size});
                    org_next[1] = ostk_reg[1][sp];
                    org_next[2] = ostk_reg[2][sp];
                    state_next = ecc_pkg::S_SQ;
                end
                else
                begin
                    // last child done: back to the parent cell
                    org_next[0] = ostk_reg[0][sp];
                    org_next[1] = ostk_reg[1][sp];
                    org_next[2] = ostk_reg[2][sp];
                    lev_next = lev_m1;
                end
            end

            ecc_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    weight_next = acc_reg;
                    out_valid_next = 1'b1;
                    state_next = ecc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ecc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            dims_reg      <= 2'd2;
            rx_reg        <= 6'd1;
            ry_reg        <= 6'd1;
            rz_reg        <= 6'd1;
            depth_reg     <= 3'd3;
            refine_reg    <= 3'd2;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ecc_pkg::REG_DIMENSIONS: dims_reg   <= cfg_data[1:0];
                    ecc_pkg::REG_RADIUS_X:   rx_reg     <= cfg_data;
                    ecc_pkg::REG_RADIUS_Y:   ry_reg     <= cfg_data;
                    ecc_pkg::REG_RADIUS_Z:   rz_reg     <= cfg_data;
                    ecc_pkg::REG_DEPTH:      depth_reg  <= cfg_data[2:0];
                    ecc_pkg::REG_REFINEMENT: refine_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        oz_reg <= oz_next;
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        rz2_reg <= rz2_next;
        coef_reg <= coef_next;
        ch_reg <= ch_next;
        pw_reg <= pw_next;
        fl_reg <= fl_next;
        bnd_reg <= bnd_next;
        org_reg <= org_next;
        ostk_reg <= ostk_next;
        idx_stk_reg <= idx_stk_next;
        lev_reg <= lev_next;
        corner_reg <= corner_next;
        axis_reg <= axis_next;
        seen_in_reg <= seen_in_next;
        seen_out_reg <= seen_out_next;
        sum_reg <= sum_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        weight_reg <= weight_next;
    end

endmodule

// ----- rtl/ecc_mul.sv -----
`timescale 1ns / 1ps

// shared unsigned multiplier used by the setup program and the square and coefficient steps
module ecc_mul (
    input  logic [ecc_pkg::MUL_W-1:0]   a,
    input  logic [ecc_pkg::MUL_W-1:0]   b,
    output logic [2*ecc_pkg::MUL_W-1:0] p
);

    assign p = a * b;

endmodule

// ----- rtl/ecc_checker.sv -----
`timescale 1ns / 1ps

module ecc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ecc_pkg::WEIGHT_W-1:0] weight_units
);

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(weight_units))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // the setup program runs before any result, so no result right after a take
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // weight never exceeds 2^25, the full weight of a cell at the largest settings
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!weight_units[25] || weight_units[24:0] == 25'd0))
        else $error("weight out of range");

endmodule

bind ellipse_cell_coverage ecc_checker u_ecc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .weight_units (weight_units)
);
